// ===== rtl/core/tws_pkg.sv =====
// Package for the TFTP write sender: item, result and configuration types,
// event, opcode and status codes, register indexes and default sizes.
// No dependencies.
package tws_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int MAX_RETRIES_DEF = 5;

    localparam int DATA_LENGTH_W = 25;
    localparam int MAX_RETRIES_W = 4;
    localparam int CFG_DATA_W    = 25;
    localparam int CFG_INDEX_W   = 1;
    localparam int BLOCK_W       = 16;
    localparam int LEN_W         = 10;
    localparam int TMO_CNT_W     = 5;

    // event kinds
    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_HEADER  = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // transmitted opcodes
    localparam logic [1:0] OP_WRQ  = 2'd2;
    localparam logic [1:0] OP_DATA = 2'd3;

    // received opcodes
    localparam logic [15:0] RX_OP_ACK   = 16'd4;
    localparam logic [15:0] RX_OP_ERROR = 16'd5;

    // transfer status
    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_REMOTE  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES = 1'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] rx_opcode;
        logic [15:0] rx_block;
    } tws_in_t;

    typedef struct packed {
        logic                     send;
        logic [1:0]               tx_opcode;
        logic [BLOCK_W-1:0]       tx_block;
        logic [DATA_LENGTH_W-1:0] data_offset;
        logic [LEN_W-1:0]         data_len;
        logic                     done_res;
        logic [2:0]               status;
    } tws_out_t;

    typedef struct packed {
        logic [DATA_LENGTH_W-1:0] data_length;
        logic [MAX_RETRIES_W-1:0] max_retries;
    } tws_cfg_t;

endpackage

// ===== rtl/core/tws_pipe_reg.sv =====
// One valid/ready pipeline register for a packed payload type.
// Depends on nothing; the payload type comes in as a parameter.
module tws_pipe_reg #(
    parameter type data_t = logic
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  data_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output data_t out_data
);

    logic  valid_reg;
    logic  valid_next;
    data_t data_reg;

    // take a new item whenever the held one leaves or none is held
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/core/tws_engine.sv =====
// Transfer state and one-pass decision logic of the TFTP write sender.
// Depends on tws_pkg.
module tws_engine #(
    parameter int BlockBytes = tws_pkg::BLOCK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  tws_pkg::tws_in_t  item,
    input  tws_pkg::tws_cfg_t cfg,
    output tws_pkg::tws_out_t result
);
    import tws_pkg::*;

    localparam int OFS_W = BLOCK_W + $clog2(BlockBytes);
    localparam int CMP_W = (OFS_W > DATA_LENGTH_W) ? OFS_W : DATA_LENGTH_W;

    logic [BLOCK_W-1:0]       exp_blk_reg,    exp_blk_next;
    logic [TMO_CNT_W-1:0]     tmo_cnt_reg,    tmo_cnt_next;
    logic                     finished_reg,   finished_next;
    logic [2:0]               fin_status_reg, fin_status_next;
    logic [1:0]               last_op_reg,    last_op_next;
    logic [BLOCK_W-1:0]       last_blk_reg,   last_blk_next;
    logic [LEN_W-1:0]         last_len_reg,   last_len_next;
    logic [DATA_LENGTH_W-1:0] last_ofs_reg,   last_ofs_next;

    logic [CMP_W-1:0] ofs;
    logic [CMP_W-1:0] dlen_ext;
    logic [CMP_W-1:0] remain;
    logic [CMP_W-1:0] blk_len;
    logic             emit;

    // byte offset of the block after the acked one, and what is left of the data
    assign ofs      = CMP_W'(item.rx_block) * CMP_W'(BlockBytes);
    assign dlen_ext = CMP_W'(cfg.data_length);
    assign remain   = dlen_ext - ofs;
    assign blk_len  = (remain > CMP_W'(BlockBytes)) ? CMP_W'(BlockBytes) : remain;

    always_comb begin
        exp_blk_next    = exp_blk_reg;
        tmo_cnt_next    = tmo_cnt_reg;
        finished_next   = finished_reg;
        fin_status_next = fin_status_reg;
        last_op_next    = last_op_reg;
        last_blk_next   = last_blk_reg;
        last_len_next   = last_len_reg;
        last_ofs_next   = last_ofs_reg;
        emit            = 1'b0;

        case (item.func)
            FUNC_START: begin
                exp_blk_next    = '0;
                tmo_cnt_next    = '0;
                last_op_next    = OP_WRQ;
                last_blk_next   = '0;
                last_len_next   = '0;
                last_ofs_next   = '0;
                if (cfg.data_length == '0) begin
                    finished_next   = 1'b1;
                    fin_status_next = ST_EMPTY;
                end else begin
                    finished_next   = 1'b0;
                    fin_status_next = ST_RUN;
                    emit            = 1'b1;
                end
            end
            FUNC_HEADER: begin
                if (!finished_reg) begin
                    tmo_cnt_next = '0;
                    if (item.rx_opcode == RX_OP_ERROR) begin
                        finished_next   = 1'b1;
                        fin_status_next = ST_REMOTE;
                    end else if (item.rx_block == exp_blk_reg) begin
                        exp_blk_next = exp_blk_reg + BLOCK_W'(1);
                        if (item.rx_opcode == RX_OP_ACK) begin
                            if (ofs > dlen_ext) begin
                                finished_next   = 1'b1;
                                fin_status_next = ST_OK;
                            end else begin
                                last_op_next  = OP_DATA;
                                last_blk_next = item.rx_block + BLOCK_W'(1);
                                last_len_next = blk_len[LEN_W-1:0];
                                last_ofs_next = ofs[DATA_LENGTH_W-1:0];
                                emit          = 1'b1;
                            end
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end
            end
            FUNC_TIMEOUT: begin
                if (!finished_reg) begin
                    tmo_cnt_next = tmo_cnt_reg + TMO_CNT_W'(1);
                    if (tmo_cnt_next > TMO_CNT_W'(cfg.max_retries)) begin
                        finished_next   = 1'b1;
                        fin_status_next = ST_TIMEOUT;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (emit) begin
            result.send      = 1'b1;
            result.tx_opcode = last_op_next;
            if (last_op_next == OP_DATA) begin
                result.tx_block    = last_blk_next;
                result.data_offset = last_ofs_next;
                result.data_len    = last_len_next;
            end
        end
        result.done_res = finished_next;
        result.status   = fin_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_blk_reg    <= '0;
            tmo_cnt_reg    <= '0;
            finished_reg   <= 1'b1;
            fin_status_reg <= ST_RUN;
            last_op_reg    <= OP_WRQ;
            last_blk_reg   <= '0;
            last_len_reg   <= '0;
            last_ofs_reg   <= '0;
        end else if (fire) begin
            exp_blk_reg    <= exp_blk_next;
            tmo_cnt_reg    <= tmo_cnt_next;
            finished_reg   <= finished_next;
            fin_status_reg <= fin_status_next;
            last_op_reg    <= last_op_next;
            last_blk_reg   <= last_blk_next;
            last_len_reg   <= last_len_next;
            last_ofs_reg   <= last_ofs_next;
        end
    end

endmodule

// ===== rtl/core/tftp_write_sender.sv =====
// Top level of the TFTP write sender: configuration registers, input and
// result registers around the decision engine.
// Depends on tws_pkg, tws_pipe_reg and tws_engine.
//
//   port group   direction  handshake          payload
//   s_*          in         s_valid / s_ready  s_data  (tws_in_t event item)
//   m_*          out        m_valid / m_ready  m_data  (tws_out_t result item)
//   cfg_*        in         cfg_wr_en only     cfg_index, cfg_wdata
//
// One result item per event item; a new item is taken every cycle while m_ready
// is high. The input register takes the item, and the engine then decides in
// one pass and loads the result register, which drives m_valid.
// Reset (aresetn low, synchronous) empties both registers and leaves the
// engine idle and finished with status running until the first start event.
// A stalled m_ready holds the result register; the input register then holds
// one more item, and s_ready drops only when both are full.
module tftp_write_sender #(
    parameter int BlockBytes = tws_pkg::BLOCK_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tws_pkg::tws_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tws_pkg::tws_out_t                 m_data,
    input  logic                              cfg_wr_en,
    input  logic [tws_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tws_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import tws_pkg::*;

    tws_cfg_t cfg_reg;
    tws_in_t  item;
    tws_out_t result;
    logic     item_valid;
    logic     res_ready;

    // configuration writes take effect at once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_length <= '0;
            cfg_reg.max_retries <= MAX_RETRIES_W'(MAX_RETRIES_DEF);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DATA_LENGTH: cfg_reg.data_length <= cfg_wdata[DATA_LENGTH_W-1:0];
                REG_MAX_RETRIES: cfg_reg.max_retries <= cfg_wdata[MAX_RETRIES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register: holds the event while the engine's result waits
    tws_pipe_reg #(
        .data_t (tws_in_t)
    ) u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (item_valid),
        .out_ready (res_ready),
        .out_data  (item)
    );

    // engine updates its state only when its result enters the result register
    tws_engine #(
        .BlockBytes (BlockBytes)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (item_valid && res_ready),
        .item    (item),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // result register: parts the engine from the downstream stall
    tws_pipe_reg #(
        .data_t (tws_out_t)
    ) u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_ready  (res_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/core/tws_checker.sv =====
// Port-level checks of the TFTP write sender, bound to the top level.
// Depends on tws_pkg and tftp_write_sender.
module tws_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input tws_pkg::tws_out_t m_data
);
    import tws_pkg::*;

    // no result item right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result item visible after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result item changed");

    // a sent packet is a write request or a data block
    a_send_op: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.send |->
            (m_data.tx_opcode == OP_WRQ || m_data.tx_opcode == OP_DATA))
        else $error("bad transmit opcode");

    // only data sends carry block fields
    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_data.send && m_data.tx_opcode == OP_DATA) |->
            (m_data.tx_block == '0 && m_data.data_offset == '0 &&
             m_data.data_len == '0))
        else $error("block fields set without a data send");

    // a running transfer reports status running and never sends after the end
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.done_res || m_data.status == ST_RUN) &&
                    !(m_data.done_res && m_data.send))
        else $error("status inconsistent with done");

endmodule

bind tftp_write_sender tws_checker u_tws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/tftp_write_sender_test.sv =====
// Testbench for tftp_write_sender: drives event items, predicts each result item
// as its event is accepted and checks the result stream field by field.
// Depends on tws_pkg and the tftp_write_sender RTL.
module tftp_write_sender_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tws_pkg::*;

    localparam int BLOCK_BYTES = BLOCK_BYTES_DEF;

    // The package names three event kinds; the fourth code must be ignored.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [DATA_LENGTH_W-1:0] DATA_LENGTH_MAX = '1;
    localparam logic [MAX_RETRIES_W-1:0] RETRIES_MAX     = '1;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int BURST_ACKS     = 200;   // acks sent back to back with no idling
    localparam int QUIET_TAIL     = 200;   // last random items run with no idling
    localparam int HOLD_OFF_LEN   = 60;    // long receiver stall for the pressure test
    localparam int DRAIN_CYCLES   = 4;     // margin after the last result item
    localparam int MISMATCH_LINES = 40;
    localparam int RUN_LIMIT_NS   = 1_500_000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    tws_in_t                  s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    tws_out_t                 m_data;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    // Shadow of the configuration registers and of the sender's state, with
    // the values they take at reset.
    logic [DATA_LENGTH_W-1:0] cfg_length  = '0;
    logic [MAX_RETRIES_W-1:0] cfg_retries = MAX_RETRIES_W'(MAX_RETRIES_DEF);
    logic [BLOCK_W-1:0]       next_block  = '0;
    logic [TMO_CNT_W-1:0]     tmo_run     = '0;
    logic                     xfer_over   = 1'b1;
    logic [2:0]               xfer_status = ST_RUN;
    logic [1:0]               held_op     = OP_WRQ;
    logic [BLOCK_W-1:0]       held_block  = '0;
    logic [LEN_W-1:0]         held_len    = '0;

    tws_out_t    pending_results[$];
    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    bit          sender_gaps   = 1'b0;
    bit          receiver_gaps = 1'b0;
    int unsigned hold_request  = 0;

    tftp_write_sender dut (.*);

    initial forever #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Packet that goes out again on a retransmit: the write request, or the
    // last data block with its offset derived from the block number.
    function automatic tws_out_t repeat_packet();
        tws_out_t           pkt;
        logic [BLOCK_W-1:0] prev;
        pkt           = '0;
        pkt.send      = 1'b1;
        pkt.tx_opcode = held_op;
        if (held_op == OP_DATA) begin
            // block numbers wrap, so block 0 follows 65535 and sits at the top
            prev            = held_block - 1'b1;
            pkt.tx_block    = held_block;
            pkt.data_offset = DATA_LENGTH_W'(prev * BLOCK_BYTES);
            pkt.data_len    = held_len;
        end
        return pkt;
    endfunction

    function automatic void end_transfer(input logic [2:0] st);
        xfer_over   = 1'b1;
        xfer_status = st;
    endfunction

    // Advance the shadow state by one event and return the result item it causes.
    function automatic tws_out_t decide_event(input tws_in_t ev);
        tws_out_t        res;
        longint unsigned start_byte;
        longint unsigned left;
        res = '0;
        case (ev.func)
            FUNC_START: begin
                next_block  = '0;
                tmo_run     = '0;
                xfer_over   = 1'b0;
                xfer_status = ST_RUN;
                held_op     = OP_WRQ;
                held_block  = '0;
                held_len    = '0;
                if (cfg_length == '0) begin
                    end_transfer(ST_EMPTY);
                end else begin
                    res = repeat_packet();
                end
            end
            FUNC_HEADER: begin
                if (!xfer_over) begin
                    // any header clears the timeout run, even one that is ignored
                    tmo_run = '0;
                    if (ev.rx_opcode == RX_OP_ERROR) begin
                        end_transfer(ST_REMOTE);
                    end else if (ev.rx_block == next_block) begin
                        next_block = next_block + 1'b1;
                        if (ev.rx_opcode == RX_OP_ACK) begin
                            start_byte = ev.rx_block;
                            start_byte = start_byte * BLOCK_BYTES;
                            if (start_byte > cfg_length) begin
                                end_transfer(ST_OK);
                            end else begin
                                // final block may be short or empty
                                left = cfg_length - start_byte;
                                if (left > BLOCK_BYTES) left = BLOCK_BYTES;
                                held_op    = OP_DATA;
                                held_block = next_block;
                                held_len   = LEN_W'(left);
                                res        = repeat_packet();
                            end
                        end else begin
                            // matching header of another kind: resend, block still advances
                            res = repeat_packet();
                        end
                    end
                end
            end
            FUNC_TIMEOUT: begin
                if (!xfer_over) begin
                    tmo_run = tmo_run + 1'b1;
                    if (tmo_run > cfg_retries) begin
                        end_transfer(ST_TIMEOUT);
                    end else begin
                        res = repeat_packet();
                    end
                end
            end
            default: ;
        endcase
        res.done_res = xfer_over;
        res.status   = xfer_status;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Offer one item and hold it until accepted; valid stays high afterwards
    // so back-to-back items go out without a bubble.
    task automatic send_item(input logic [1:0] func, input logic [15:0] op,
                             input logic [15:0] blk);
        tws_in_t ev;
        ev.func      = func;
        ev.rx_opcode = op;
        ev.rx_block  = blk;
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(decide_event(ev));
        items_sent++;
    endtask

    // Drop valid and wait until every expected result item has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_DATA_LENGTH) cfg_length = value[DATA_LENGTH_W-1:0];
        else cfg_retries = value[MAX_RETRIES_W-1:0];
    endtask

    // Receiver: ready by default, random stall bursts when enabled, and a
    // long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
                m_ready <= 1'b1;
            end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MISMATCH_LINES)
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tws_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_LINES)
                    $display("%0t ns: result item with none expected, actual %0h",
                             $time, m_data);
            end else begin
                want = pending_results.pop_front();
                compare_field("send", want.send, m_data.send);
                compare_field("tx_opcode", want.tx_opcode, m_data.tx_opcode);
                compare_field("tx_block", want.tx_block, m_data.tx_block);
                compare_field("data_offset", want.data_offset, m_data.data_offset);
                compare_field("data_len", want.data_len, m_data.data_len);
                compare_field("done_res", want.done_res, m_data.done_res);
                compare_field("status", want.status, m_data.status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Before any start the sender reports finished with status running and
    // ignores headers, timeouts and the unused event kind.
    task automatic test_idle_after_reset();
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd0);
        send_item(FUNC_TIMEOUT, rnd16(), rnd16());
        send_item(FUNC_UNUSED, rnd16(), rnd16());
    endtask

    // Zero length ends at once with status empty; later events change nothing.
    task automatic test_empty_data();
        write_reg(REG_DATA_LENGTH, '0);
        send_item(FUNC_START, 16'hFFFF, 16'hFFFF);
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd0);
        send_item(FUNC_TIMEOUT, rnd16(), rnd16());
    endtask

    // Exact multiple of the block size: timeout resend, stray block ignored,
    // matching non-ack resend, empty final block, then ok.
    task automatic test_full_transfer();
        write_reg(REG_DATA_LENGTH, CFG_DATA_W'(2 * BLOCK_BYTES));
        write_reg(REG_MAX_RETRIES, CFG_DATA_W'(RETRIES_MAX));
        send_item(FUNC_START, rnd16(), rnd16());
        send_item(FUNC_TIMEOUT, rnd16(), rnd16());
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd0);
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd7);
        send_item(FUNC_HEADER, 16'hFFFF, 16'd1);
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd2);
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd3);
        send_item(FUNC_TIMEOUT, rnd16(), rnd16());
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd4);
    endtask

    task automatic test_remote_error();
        send_item(FUNC_START, rnd16(), rnd16());
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd0);
        send_item(FUNC_HEADER, RX_OP_ERROR, rnd16());
    endtask

    // Short final block, then a single timeout is already too many.
    task automatic test_retry_limit();
        write_reg(REG_DATA_LENGTH, CFG_DATA_W'(700));
        write_reg(REG_MAX_RETRIES, '0);
        send_item(FUNC_START, rnd16(), rnd16());
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd0);
        send_item(FUNC_HEADER, RX_OP_ACK, 16'd1);
        send_item(FUNC_TIMEOUT, rnd16(), rnd16());
    endtask

    // Full-size data acked block after block with no idling on either side,
    // so a new item goes in on every cycle.
    task automatic test_back_to_back();
        int unsigned blk;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        write_reg(REG_DATA_LENGTH, CFG_DATA_W'(DATA_LENGTH_MAX));
        write_reg(REG_MAX_RETRIES, CFG_DATA_W'(MAX_RETRIES_DEF));
        send_item(FUNC_START, rnd16(), rnd16());
        for (blk = 0; blk < BURST_ACKS; blk++)
            send_item(FUNC_HEADER, RX_OP_ACK, 16'(blk));
    endtask

    // Hold the receiver off for a long stretch while items keep coming, so the
    // two internal registers fill and the input stalls.
    task automatic test_backpressure();
        int unsigned blk;
        write_reg(REG_DATA_LENGTH, CFG_DATA_W'(5000));
        hold_request = HOLD_OFF_LEN;
        send_item(FUNC_START, rnd16(), rnd16());
        for (blk = 0; blk < 10; blk++)
            send_item(FUNC_HEADER, RX_OP_ACK, 16'(blk));
    endtask

    task automatic pick_config();
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] tries;
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = CFG_DATA_W'(DATA_LENGTH_MAX);
            2:       len = CFG_DATA_W'($urandom_range(1, 16) * BLOCK_BYTES);
            3:       len = CFG_DATA_W'($urandom_range(0, DATA_LENGTH_MAX));
            default: len = CFG_DATA_W'($urandom_range(1, 6000));
        endcase
        case ($urandom_range(0, 3))
            0:       tries = '0;
            1:       tries = CFG_DATA_W'(RETRIES_MAX);
            default: tries = CFG_DATA_W'($urandom_range(0, RETRIES_MAX));
        endcase
        if ($urandom_range(0, 3) != 0) write_reg(REG_DATA_LENGTH, len);
        if ($urandom_range(0, 1) != 0) write_reg(REG_MAX_RETRIES, tries);
    endtask

    // One transfer: mostly acks for the expected block (in a storm, mostly timeouts),
    // mixed with timeouts, stray and foreign headers, errors, restarts and unused events.
    task automatic run_random_transfer();
        int unsigned budget;
        int unsigned roll;
        bit          storm;
        logic [15:0] op;
        logic [1:0]  late_kinds[3];
        late_kinds = '{FUNC_HEADER, FUNC_TIMEOUT, FUNC_UNUSED};
        budget = $urandom_range(4, 80);
        storm  = ($urandom_range(0, 7) == 0);
        send_item(FUNC_START, rnd16(), rnd16());
        while (budget != 0 && !xfer_over) begin
            budget--;
            roll = $urandom_range(0, 99);
            if (storm) roll = (roll < 85) ? 60 : 0;
            if (roll < 55) begin
                send_item(FUNC_HEADER, RX_OP_ACK, next_block);
            end else if (roll < 67) begin
                send_item(FUNC_TIMEOUT, rnd16(), rnd16());
            end else if (roll < 73) begin
                op = rnd16();
                while (op == RX_OP_ACK || op == RX_OP_ERROR) op = rnd16();
                send_item(FUNC_HEADER, op, next_block);
            end else if (roll < 81) begin
                send_item(FUNC_HEADER, RX_OP_ACK,
                          next_block + 16'($urandom_range(1, 16'hFFFF)));
            end else if (roll < 87) begin
                send_item(FUNC_HEADER, rnd16(), rnd16());
            end else if (roll < 90) begin
                send_item(FUNC_HEADER, RX_OP_ERROR, rnd16());
            end else if (roll < 95) begin
                send_item(FUNC_UNUSED, rnd16(), rnd16());
            end else begin
                send_item(FUNC_START, rnd16(), rnd16());
            end
        end
        repeat ($urandom_range(0, 2))
            send_item(late_kinds[$urandom_range(0, 2)], rnd16(), rnd16());
    endtask

    task automatic test_random_traffic();
        int unsigned goal;
        bit          quiet;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            quiet         = (items_sent + QUIET_TAIL >= goal);
            sender_gaps   = !quiet && ($urandom_range(0, 2) != 0);
            receiver_gaps = !quiet && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 1) != 0) pick_config();
            run_random_transfer();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_after_reset();
        test_empty_data();
        test_full_transfer();
        test_remote_error();
        test_retry_limit();
        test_back_to_back();
        test_backpressure();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT_NS;
        $display("%0t ns: run limit reached, %0d result items outstanding",
                 $time, pending_results.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
